/* rtl/rmfp_pkg.sv */
// Package for the routing-message frame parser: codes, result type and field-size table.
`default_nettype none

package rmfp_pkg;

  // Frame positions: version byte, then the fields in wire order
  localparam logic [4:0] POS_VERSION  = 5'd0;
  localparam logic [4:0] POS_TYPE     = 5'd1;
  localparam logic [4:0] POS_DIR      = 5'd2;
  localparam logic [4:0] POS_SRC      = 5'd3;
  localparam logic [4:0] POS_DST      = 5'd4;
  localparam logic [4:0] POS_SEQ      = 5'd5;
  localparam logic [4:0] POS_START    = 5'd6;
  localparam logic [4:0] POS_LIFE     = 5'd7;
  localparam logic [4:0] POS_PREVHOP  = 5'd8;
  localparam logic [4:0] POS_HOPS     = 5'd9;
  localparam logic [4:0] POS_SINR     = 5'd10;
  localparam logic [4:0] POS_PHER     = 5'd11;
  localparam logic [4:0] POS_VIS_CNT  = 5'd12;
  localparam logic [4:0] POS_VIS_NODE = 5'd13;
  localparam logic [4:0] POS_VIS_VAL  = 5'd14;
  localparam logic [4:0] POS_HIS_CNT  = 5'd15;
  localparam logic [4:0] POS_HIS_NODE = 5'd16;
  localparam logic [4:0] POS_HIS_VAL  = 5'd17;
  localparam logic [4:0] POS_HEL_CNT  = 5'd18;
  localparam logic [4:0] POS_HEL_NODE = 5'd19;
  localparam logic [4:0] POS_HEL_VAL  = 5'd20;
  localparam logic [4:0] POS_LAST     = POS_HEL_VAL;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_VERSION   = 3'd1;
  localparam logic [2:0] ST_TYPE      = 3'd2;
  localparam logic [2:0] ST_DIR       = 3'd3;
  localparam logic [2:0] ST_VISITED   = 3'd4;
  localparam logic [2:0] ST_HISTORY   = 3'd5;
  localparam logic [2:0] ST_HELLO     = 3'd6;
  localparam logic [2:0] ST_TRUNCATED = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] CFG_WIRE_VERSION = 3'd0;
  localparam logic [2:0] CFG_TYPE_MASK    = 3'd1;
  localparam logic [2:0] CFG_DIR_MASK     = 3'd2;
  localparam logic [2:0] CFG_MAX_VISITED  = 3'd3;
  localparam logic [2:0] CFG_MAX_HISTORY  = 3'd4;
  localparam logic [2:0] CFG_MAX_HELLO    = 3'd5;

  // One result word
  typedef struct packed {
    logic        is_status;
    logic [4:0]  field_id;
    logic [15:0] element_index;
    logic [63:0] field_value;
    logic [2:0]  status_code;
    logic        last_result;
  } res_t;

  // Bytes in the field at a frame position
  function automatic logic [3:0] field_size(input logic [4:0] pos);
    logic [3:0] sz;
    case (pos)
      POS_VERSION, POS_TYPE, POS_DIR:                       sz = 4'd1;
      POS_START, POS_LIFE, POS_SINR, POS_PHER:              sz = 4'd8;
      POS_VIS_VAL, POS_HIS_VAL, POS_HEL_VAL:                sz = 4'd8;
      POS_VIS_CNT, POS_HIS_CNT, POS_HEL_CNT:                sz = 4'd2;
      default:                                              sz = 4'd4;
    endcase
    return sz;
  endfunction

  function automatic res_t mk_field(input logic [4:0] id, input logic [15:0] idx,
                                    input logic [63:0] val);
    res_t r;
    r.is_status     = 1'b0;
    r.field_id      = id;
    r.element_index = idx;
    r.field_value   = val;
    r.status_code   = ST_OK;
    r.last_result   = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_status(input logic [2:0] code);
    res_t r;
    r.is_status     = 1'b1;
    r.field_id      = 5'd0;
    r.element_index = 16'd0;
    r.field_value   = 64'd0;
    r.status_code   = code;
    r.last_result   = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/routing_message_frame_parser_core.sv */
// Routing-message frame parser: byte-wise field assembly, checks and result queue.
//
// Usage:
//   Frame bytes enter on the input channel (byte_value_i, frame_end_i) in wire
//   order, frame_end_i high on the frame's last byte. Each word on the output
//   channel is either a decoded field (field_id_o, element_index_o,
//   field_value_o) or the frame's final status (is_status_o, status_code_o).
//   last_result_o marks the last word caused by one input byte.
//   Order: a byte is held in the input register, then its words are written
//   to a three-entry result queue whose head entry drives the outputs; a
//   second word from the same byte follows once the first has been taken.
//   Throughput: one byte per cycle while each byte yields at most one word
//   and the receiver takes every word; after a byte that yields two words the
//   next byte waits for a pop. The output port drains one word per cycle and sets the pace.
//   Configuration registers are written through the cfg channel, which is
//   always ready; write them only while the parser is idle.
//   Reset clears the queue, the parse state and loads the register defaults.
//   When the receiver stalls, words wait in the queue and in_ready_o drops
//   once fewer than two queue entries are free.
`default_nettype none

module routing_message_frame_parser_core
  import rmfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        frame_end_i,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             is_status_o,
  output logic [4:0]       field_id_o,
  output logic [15:0]      element_index_o,
  output logic [63:0]      field_value_o,
  output logic [2:0]       status_code_o,
  output logic             last_result_o
);

  // configuration
  logic [7:0]  wire_version_q, type_mask_q, dir_mask_q;
  logic [15:0] max_visited_q, max_history_q, max_hello_q;

  // input register
  logic        in_v_q;
  logic [7:0]  byte_q;
  logic        fe_q;

  // parse state
  logic [4:0]  pos_q, pos_d;
  logic [2:0]  bif_q, bif_d;
  logic [63:0] asm_q, asm_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] pidx_q, pidx_d;
  logic        drain_q, drain_d;

  // result queue
  res_t        fifo_q [3];
  res_t        fifo_d [3];
  logic [1:0]  fcnt_q, fcnt_d;

  logic        proc;
  logic        pop;
  res_t        r0, r1;
  logic [1:0]  n_res;

  // Process a held byte when the queue can take two words
  assign proc        = in_v_q && (fcnt_q <= 2'd1);
  assign in_ready_o  = !in_v_q || proc;
  assign cfg_ready_o = 1'b1;
  assign pop         = out_valid_o && out_ready_i;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wire_version_q <= 8'd1;
      type_mask_q    <= 8'd15;
      dir_mask_q     <= 8'd3;
      max_visited_q  <= 16'd64;
      max_history_q  <= 16'd64;
      max_hello_q    <= 16'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIRE_VERSION: wire_version_q <= cfg_data_i[7:0];
        CFG_TYPE_MASK:    type_mask_q    <= cfg_data_i[7:0];
        CFG_DIR_MASK:     dir_mask_q     <= cfg_data_i[7:0];
        CFG_MAX_VISITED:  max_visited_q  <= cfg_data_i;
        CFG_MAX_HISTORY:  max_history_q  <= cfg_data_i;
        CFG_MAX_HELLO:    max_hello_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the incoming byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_v_q <= 1'b1;
    end else if (proc) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= byte_value_i;
      fe_q   <= frame_end_i;
    end
  end

  // Assemble fields, check codes and counts, build up to two words
  always_comb begin
    logic [63:0] word_val;
    logic        complete;
    logic        done;
    logic [15:0] pidx_inc;
    logic [15:0] limit;
    logic [2:0]  err_code;

    pos_d    = pos_q;
    bif_d    = bif_q;
    asm_d    = asm_q;
    cnt_d    = cnt_q;
    pidx_d   = pidx_q;
    drain_d  = drain_q;
    r0       = '0;
    r1       = '0;
    n_res    = 2'd0;
    done     = 1'b0;
    word_val = asm_q | (64'(byte_q) << {bif_q, 3'b000});
    complete = ({1'b0, bif_q} + 4'd1) >= field_size(pos_q);
    pidx_inc = pidx_q + 16'd1;
    limit    = max_hello_q;
    err_code = ST_HELLO;

    if (proc) begin
      if (drain_q) begin
        // drop bytes until the frame ends
        if (fe_q) begin
          pos_d   = POS_VERSION;
          bif_d   = 3'd0;
          asm_d   = 64'd0;
          cnt_d   = 16'd0;
          pidx_d  = 16'd0;
          drain_d = 1'b0;
        end
      end else begin
        if (complete) begin
          asm_d = 64'd0;
          bif_d = 3'd0;
          unique case (pos_q) inside
            POS_VERSION: begin
              if (word_val[7:0] != wire_version_q) begin
                r0    = mk_status(ST_VERSION);
                n_res = 2'd1;
                done  = 1'b1;
              end else begin
                pos_d = POS_TYPE;
              end
            end
            POS_TYPE: begin
              if (!type_mask_q[word_val[2:0]] || (word_val[7:3] != 5'd0)) begin
                r0    = mk_status(ST_TYPE);
                n_res = 2'd1;
                done  = 1'b1;
              end else begin
                r0    = mk_field(pos_q - 5'd1, 16'd0, word_val);
                n_res = 2'd1;
                pos_d = POS_DIR;
              end
            end
            POS_DIR: begin
              if (!dir_mask_q[word_val[2:0]] || (word_val[7:3] != 5'd0)) begin
                r0    = mk_status(ST_DIR);
                n_res = 2'd1;
                done  = 1'b1;
              end else begin
                r0    = mk_field(pos_q - 5'd1, 16'd0, word_val);
                n_res = 2'd1;
                pos_d = POS_SRC;
              end
            end
            POS_VIS_CNT, POS_HIS_CNT, POS_HEL_CNT: begin
              if (pos_q == POS_VIS_CNT) begin
                limit    = max_visited_q;
                err_code = ST_VISITED;
              end else if (pos_q == POS_HIS_CNT) begin
                limit    = max_history_q;
                err_code = ST_HISTORY;
              end
              if (word_val[15:0] > limit) begin
                r0    = mk_status(err_code);
                n_res = 2'd1;
                done  = 1'b1;
              end else begin
                r0     = mk_field(pos_q - 5'd1, 16'd0, word_val);
                n_res  = 2'd1;
                cnt_d  = word_val[15:0];
                pidx_d = 16'd0;
                if (word_val[15:0] == 16'd0) begin
                  // empty section: skip its pairs
                  if (pos_q == POS_HEL_CNT) begin
                    r1    = mk_status(ST_OK);
                    n_res = 2'd2;
                    done  = 1'b1;
                  end else begin
                    pos_d = pos_q + 5'd3;
                  end
                end else begin
                  pos_d = pos_q + 5'd1;
                end
              end
            end
            POS_VIS_NODE, POS_HIS_NODE, POS_HEL_NODE: begin
              r0    = mk_field(pos_q - 5'd1, pidx_q, word_val);
              n_res = 2'd1;
              pos_d = pos_q + 5'd1;
            end
            POS_VIS_VAL, POS_HIS_VAL, POS_HEL_VAL: begin
              r0     = mk_field(pos_q - 5'd1, pidx_q, word_val);
              n_res  = 2'd1;
              pidx_d = pidx_inc;
              if ((pidx_inc == cnt_q) || (pidx_inc == 16'd0)) begin
                // section finished
                if (pos_q == POS_HEL_VAL) begin
                  r1    = mk_status(ST_OK);
                  n_res = 2'd2;
                  done  = 1'b1;
                end else begin
                  pos_d = pos_q + 5'd1;
                end
              end else begin
                pos_d = pos_q - 5'd1;
              end
            end
            default: begin
              r0    = mk_field(pos_q - 5'd1, 16'd0, word_val);
              n_res = 2'd1;
              pos_d = pos_q + 5'd1;
            end
          endcase
        end else begin
          asm_d = word_val;
          bif_d = bif_q + 3'd1;
        end

        // end of frame handling
        if (done || fe_q) begin
          if (!done) begin
            if (n_res == 2'd0) begin
              r0    = mk_status(ST_TRUNCATED);
              n_res = 2'd1;
            end else begin
              r1    = mk_status(ST_TRUNCATED);
              n_res = 2'd2;
            end
          end
          if (fe_q) begin
            pos_d   = POS_VERSION;
            bif_d   = 3'd0;
            asm_d   = 64'd0;
            cnt_d   = 16'd0;
            pidx_d  = 16'd0;
            drain_d = 1'b0;
          end else begin
            drain_d = 1'b1;
          end
        end
      end
    end

    // mark the last word of this byte
    if (n_res == 2'd1) begin
      r0.last_result = 1'b1;
    end else if (n_res == 2'd2) begin
      r1.last_result = 1'b1;
    end
  end

  // Advance the parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_VERSION;
      bif_q   <= 3'd0;
      asm_q   <= 64'd0;
      cnt_q   <= 16'd0;
      pidx_q  <= 16'd0;
      drain_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      bif_q   <= bif_d;
      asm_q   <= asm_d;
      cnt_q   <= cnt_d;
      pidx_q  <= pidx_d;
      drain_q <= drain_d;
    end
  end

  // Shift out the head word, append new words behind the rest
  always_comb begin
    logic [1:0] base;
    fifo_d = fifo_q;
    base   = fcnt_q;
    if (pop) begin
      fifo_d[0] = fifo_q[1];
      fifo_d[1] = fifo_q[2];
      base      = fcnt_q - 2'd1;
    end
    if (n_res != 2'd0) begin
      fifo_d[base] = r0;
    end
    if (n_res == 2'd2) begin
      fifo_d[base + 2'd1] = r1;
    end
    fcnt_d = base + n_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= 2'd0;
    end else begin
      fcnt_q <= fcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fifo_q <= fifo_d;
  end

  // Drive the head word
  assign out_valid_o     = fcnt_q != 2'd0;
  assign is_status_o     = fifo_q[0].is_status;
  assign field_id_o      = fifo_q[0].field_id;
  assign element_index_o = fifo_q[0].element_index;
  assign field_value_o   = fifo_q[0].field_value;
  assign status_code_o   = fifo_q[0].status_code;
  assign last_result_o   = fifo_q[0].last_result;

  // Checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_LAST)
    else $error("parse position out of range");

  a_bif_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, bif_q} < field_size(pos_q))
    else $error("byte counter beyond field size");

  a_drain_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && drain_q) |-> (n_res == 2'd0))
    else $error("word produced while draining");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_status_o) |-> (field_value_o == 64'd0 && field_id_o == 5'd0))
    else $error("status word carries field data");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fcnt_q == 2'd3) |=> (fcnt_q != 2'd0 || $past(pop)))
    else $error("result queue lost words");

endmodule

`default_nettype wire
